// ===== rtl/core/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg: shared types and constants of the cache tag lookup
// Configuration register codes, reset values, field widths and status types.
// ----------------------------------------------------------------------------
package sacl_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_LRU     = 2'd3;

  localparam logic [2:0] RST_OFFSET_BITS = 3'd1;
  localparam logic [2:0] RST_INDEX_BITS  = 3'd3;
  localparam logic [2:0] RST_WAYS_LOG    = 3'd0;
  localparam logic       RST_USE_LRU     = 1'b1;

  // geometry limits: index bits and ways log each saturate here
  localparam int GEO_MAX = 5;

  // result fields
  localparam int SET_W = 5;
  localparam int WAY_W = 5;

  // recency rank, 0 is most recent, saturates at all ones
  localparam int              RANK_W   = 5;
  localparam logic [RANK_W-1:0] RANK_MAX = 5'd31;

  // pseudo-random victim generator
  localparam int              LFSR_W    = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  typedef struct packed {
    logic [2:0] offset_bits;
    logic [2:0] index_bits;
    logic [2:0] ways_log;
    logic       use_lru;
  } cfg_t;

  // back part status seen by the front part
  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_stat_t;

endpackage

// ===== rtl/core/sacl_if.sv =====
// ----------------------------------------------------------------------------
// sacl_if: request and response channels of the cache tag lookup
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sacl_in_if #(
  parameter int ADDRESS_BITS = 32
);
  logic                    valid;
  logic                    ready;
  logic [ADDRESS_BITS-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface sacl_out_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [sacl_pkg::SET_W-1:0]  set_number;
  logic [sacl_pkg::WAY_W-1:0]  way_used;

  modport source (output valid, output hit, output set_number, output way_used,
                  input ready);
  modport sink   (input valid, input hit, input set_number, input way_used,
                  output ready);
endinterface

// ===== rtl/core/sacl_ram.sv =====
// ----------------------------------------------------------------------------
// sacl_ram: generic simple dual-port RAM
// One write port and one read port, registered read, old data on collision.
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sacl_front.sv =====
// ----------------------------------------------------------------------------
// sacl_front: address split and request queue
// Splits each address into set, tag and tag-row position, queues it for the
// back part.
// ----------------------------------------------------------------------------
module sacl_front #(
  parameter int MAX_ENTRIES  = 32,
  parameter int ADDRESS_BITS = 32,
  localparam int CAP    = $clog2(MAX_ENTRIES + 1) - 1,
  localparam int LANE_W = (CAP >= 5) ? 5 : CAP,
  localparam int ROW_AW = (CAP > LANE_W) ? CAP - LANE_W : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sacl_pkg::cfg_t             cfg,
  input  sacl_pkg::bk_stat_t         stat,
  sacl_in_if.sink                    req,
  output logic                       q_valid,
  output logic [ADDRESS_BITS-1:0]    q_tag,
  output logic [sacl_pkg::SET_W-1:0] q_set,
  output logic [ROW_AW-1:0]          q_row,
  output logic [LANE_W-1:0]          q_lane,
  output logic [2:0]                 q_wl
);

  localparam int QD  = 2;
  localparam int QPW = 1;

  logic [ADDRESS_BITS-1:0]    shifted;
  logic [2:0]                 a_sat, a_eff, b_sat, b_eff;
  logic [3:0]                 cap_c, room;
  logic [sacl_pkg::SET_W-1:0] smask, set_c;
  logic [ADDRESS_BITS-1:0]    tag_c;
  logic [CAP-1:0]             base;
  logic [ROW_AW-1:0]          row_c;
  logic [LANE_W-1:0]          lane_c;
  logic                       push;

  logic [ADDRESS_BITS-1:0]    tag_m  [QD];
  logic [sacl_pkg::SET_W-1:0] set_m  [QD];
  logic [ROW_AW-1:0]          row_m  [QD];
  logic [LANE_W-1:0]          lane_m [QD];
  logic [2:0]                 wl_m   [QD];
  logic [QPW-1:0]             wr_ptr, rd_ptr;
  logic [1:0]                 count;

  // effective geometry: saturate, then fit sets * ways into the store
  always_comb begin
    cap_c = 4'(CAP);
    a_sat = (cfg.index_bits > 3'(sacl_pkg::GEO_MAX)) ? 3'(sacl_pkg::GEO_MAX)
                                                     : cfg.index_bits;
    a_eff = ({1'b0, a_sat} > cap_c) ? 3'(cap_c) : a_sat;
    room  = cap_c - {1'b0, a_eff};
    b_sat = (cfg.ways_log > 3'(sacl_pkg::GEO_MAX)) ? 3'(sacl_pkg::GEO_MAX)
                                                   : cfg.ways_log;
    b_eff = ({1'b0, b_sat} > room) ? 3'(room) : b_sat;

    shifted = req.address >> cfg.offset_bits;
    smask   = 5'((6'd1 << a_eff) - 6'd1);
    set_c   = 5'(shifted) & smask;
    tag_c   = shifted >> a_eff;
    base    = CAP'(10'(set_c) << b_eff);
    row_c   = ROW_AW'(base >> LANE_W);
    lane_c  = LANE_W'(base);
  end

  assign req.ready = (count != 2'(QD)) && !stat.clearing;
  assign push      = req.valid && req.ready;
  assign q_valid   = (count != 2'd0);

  assign q_tag  = tag_m[rd_ptr];
  assign q_set  = set_m[rd_ptr];
  assign q_row  = row_m[rd_ptr];
  assign q_lane = lane_m[rd_ptr];
  assign q_wl   = wl_m[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (stat.pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, stat.pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      tag_m[wr_ptr]  <= tag_c;
      set_m[wr_ptr]  <= set_c;
      row_m[wr_ptr]  <= row_c;
      lane_m[wr_ptr] <= lane_c;
      wl_m[wr_ptr]   <= b_eff;
    end
  end

endmodule

// ===== rtl/core/sacl_back.sv =====
// ----------------------------------------------------------------------------
// sacl_back: tag row lookup and update
// Reads one tag row, finds hit, empty way or victim, updates recency and
// writes the row back; clears the store after reset.
// ----------------------------------------------------------------------------
module sacl_back #(
  parameter int MAX_ENTRIES  = 32,
  parameter int ADDRESS_BITS = 32,
  localparam int CAP     = $clog2(MAX_ENTRIES + 1) - 1,
  localparam int LANE_W  = (CAP >= 5) ? 5 : CAP,
  localparam int LANES   = 2 ** LANE_W,
  localparam int ROWS    = 2 ** (CAP - LANE_W),
  localparam int ROW_AW  = (CAP > LANE_W) ? CAP - LANE_W : 1,
  localparam int ENTRY_W = 1 + sacl_pkg::RANK_W + ADDRESS_BITS,
  localparam int ROW_W   = LANES * ENTRY_W
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sacl_pkg::cfg_t             cfg,
  input  logic                       q_valid,
  input  logic [ADDRESS_BITS-1:0]    q_tag,
  input  logic [sacl_pkg::SET_W-1:0] q_set,
  input  logic [ROW_AW-1:0]          q_row,
  input  logic [LANE_W-1:0]          q_lane,
  input  logic [2:0]                 q_wl,
  output sacl_pkg::bk_stat_t         stat,
  sacl_out_if.source                 rsp
);

  localparam int RW = sacl_pkg::RANK_W;
  localparam int AB = ADDRESS_BITS;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_LOOK = 2'd2;

  logic [1:0]                 state;
  logic [ROW_AW-1:0]          clr_row;
  logic                       pop;

  logic [AB-1:0]              cur_tag;
  logic [sacl_pkg::SET_W-1:0] cur_set;
  logic [ROW_AW-1:0]          cur_row;
  logic [LANE_W-1:0]          cur_lane;
  logic [2:0]                 cur_wl;
  logic                       fwd;

  logic                       wr_en;
  logic [ROW_AW-1:0]          wr_row;
  logic [ROW_W-1:0]           wr_data;
  logic [sacl_pkg::LFSR_W-1:0] lfsr;

  logic                       rsp_valid;
  logic                       rsp_hit;
  logic [sacl_pkg::SET_W-1:0] rsp_set;
  logic [sacl_pkg::WAY_W-1:0] rsp_way;

  logic                       ram_we;
  logic [ROW_AW-1:0]          ram_waddr;
  logic [ROW_W-1:0]           ram_wdata;
  logic [ROW_W-1:0]           ram_rdata;

  logic [ROW_W-1:0]           row;
  logic [ROW_W-1:0]           new_row;
  logic [LANES-1:0]           lv, in_set, hitv, emptyv, cand, bsel;
  logic [RW-1:0]              rk [LANES];
  logic [AB-1:0]              tg [LANES];
  logic [LANE_W-1:0]          wmask, sel, rand_lane;
  logic [sacl_pkg::LFSR_W-1:0] lfsr_nx;
  logic                       hit_c, step_lfsr, was_valid;
  logic [RW-1:0]              old_rank;

  function automatic logic [LANE_W-1:0] first_one(input logic [LANES-1:0] v);
    logic [LANE_W-1:0] r;
    r = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = LANE_W'(i);
      end
    end
    return r;
  endfunction

  sacl_ram #(
    .WIDTH(ROW_W),
    .DEPTH(ROWS)
  ) u_tag_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(q_row),
    .rdata(ram_rdata)
  );

  assign pop           = (state == ST_IDLE) && q_valid && (!rsp_valid || rsp.ready);
  assign stat.pop      = pop;
  assign stat.clearing = (state == ST_CLR);

  assign ram_we    = (state == ST_CLR) || wr_en;
  assign ram_waddr = (state == ST_CLR) ? clr_row : wr_row;
  assign ram_wdata = (state == ST_CLR) ? '0 : wr_data;

  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_hit;
  assign rsp.set_number = rsp_set;
  assign rsp.way_used   = rsp_way;

  // lookup and row update, valid in ST_LOOK
  always_comb begin
    row   = fwd ? wr_data : ram_rdata;
    wmask = LANE_W'((6'd1 << cur_wl) - 6'd1);
    for (int l = 0; l < LANES; l++) begin
      lv[l]     = row[l*ENTRY_W + ENTRY_W - 1];
      rk[l]     = row[l*ENTRY_W + AB +: RW];
      tg[l]     = row[l*ENTRY_W +: AB];
      in_set[l] = (LANE_W'(l) & ~wmask) == (cur_lane & ~wmask);
      hitv[l]   = in_set[l] && lv[l] && (tg[l] == cur_tag);
      emptyv[l] = in_set[l] && !lv[l];
    end

    // lowest lane among those with the largest rank, one rank bit a step
    cand = in_set;
    for (int b = RW - 1; b >= 0; b--) begin
      for (int l = 0; l < LANES; l++) begin
        bsel[l] = cand[l] && rk[l][b];
      end
      if (|bsel) begin
        cand = bsel;
      end
    end

    lfsr_nx   = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[sacl_pkg::LFSR_W-1:1]};
    rand_lane = cur_lane | (LANE_W'(lfsr_nx) & wmask);

    hit_c     = |hitv;
    step_lfsr = 1'b0;
    if (hit_c) begin
      sel = first_one(hitv);
    end else if (|emptyv) begin
      sel = first_one(emptyv);
    end else if (cfg.use_lru) begin
      sel = first_one(cand);
    end else begin
      sel       = rand_lane;
      step_lfsr = 1'b1;
    end

    old_rank  = rk[sel];
    was_valid = lv[sel];

    new_row = row;
    for (int l = 0; l < LANES; l++) begin
      if (LANE_W'(l) == sel) begin
        new_row[l*ENTRY_W +: ENTRY_W] = {1'b1, RW'(0), cur_tag};
      end else if (in_set[l] && lv[l] && (!was_valid || rk[l] < old_rank)) begin
        new_row[l*ENTRY_W + AB +: RW] = (rk[l] == sacl_pkg::RANK_MAX) ? rk[l]
                                                                      : rk[l] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_row   <= '0;
      wr_en     <= 1'b0;
      lfsr      <= sacl_pkg::LFSR_SEED;
      rsp_valid <= 1'b0;
    end else begin
      wr_en <= (state == ST_LOOK);
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == ROW_AW'(ROWS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state     <= ST_IDLE;
          rsp_valid <= 1'b1;
          if (step_lfsr) begin
            lfsr <= lfsr_nx;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_tag  <= q_tag;
      cur_set  <= q_set;
      cur_row  <= q_row;
      cur_lane <= q_lane;
      cur_wl   <= q_wl;
      // row written back in this cycle reads stale from the ram
      fwd      <= wr_en && (q_row == wr_row);
    end
    if (state == ST_LOOK) begin
      wr_row  <= cur_row;
      wr_data <= new_row;
      rsp_hit <= hit_c;
      rsp_set <= cur_set;
      rsp_way <= sacl_pkg::WAY_W'(sel & wmask);
    end
  end

endmodule

// ===== rtl/core/set_assoc_cache_tag_lookup.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup: set-associative cache tag lookup
// Reports hit or miss per address and keeps tags, valid bits and recency
// ranks; victims by least recently used or pseudo-random choice.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                        transfer when
//  -------  ---  -----------------------------  ------------------------
//  req      in   address                        req.valid & req.ready
//  rsp      out  hit, set_number, way_used      rsp.valid & rsp.ready
//  cfg      in   cfg_index, cfg_wdata           cfg_we
//
//  accesses go one at a time: a tag-row ram read, then compare, victim
//  choice and recency update; the row write-back overlaps the next read
//  after reset a clearing pass wipes the tag rows; req.ready stays low
//  until it is done
//  a 2-entry queue sits between address split and lookup, and the result
//  register holds a response until it is taken; the user must write
//  configuration only while no access is in flight, unchecked by the block
//
module set_assoc_cache_tag_lookup #(
  parameter int MAX_ENTRIES  = 32,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  sacl_in_if.sink                              req,
  sacl_out_if.source                           rsp,
  input  logic                                 cfg_we,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // store holds 2^CAP entries, packed 32 (or fewer) entries to a ram row
  localparam int CAP    = $clog2(MAX_ENTRIES + 1) - 1;
  localparam int LANE_W = (CAP >= 5) ? 5 : CAP;
  localparam int ROW_AW = (CAP > LANE_W) ? CAP - LANE_W : 1;

  sacl_pkg::cfg_t             cfg;
  sacl_pkg::bk_stat_t         stat;

  // queue head, classified access waiting for the lookup
  logic                       q_valid;
  logic [ADDRESS_BITS-1:0]    q_tag;
  logic [sacl_pkg::SET_W-1:0] q_set;
  logic [ROW_AW-1:0]          q_row;
  logic [LANE_W-1:0]          q_lane;
  logic [2:0]                 q_wl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_bits <= sacl_pkg::RST_OFFSET_BITS;
      cfg.index_bits  <= sacl_pkg::RST_INDEX_BITS;
      cfg.ways_log    <= sacl_pkg::RST_WAYS_LOG;
      cfg.use_lru     <= sacl_pkg::RST_USE_LRU;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sacl_pkg::CFG_OFFSET_BITS: cfg.offset_bits <= cfg_wdata;
        sacl_pkg::CFG_INDEX_BITS:  cfg.index_bits  <= cfg_wdata;
        sacl_pkg::CFG_WAYS_LOG:    cfg.ways_log    <= cfg_wdata;
        sacl_pkg::CFG_USE_LRU:     cfg.use_lru     <= cfg_wdata[0];
        default:                   cfg.use_lru     <= cfg.use_lru;
      endcase
    end
  end

  // front: address split by the effective geometry, then the queue
  sacl_front #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .stat   (stat),
    .req    (req),
    .q_valid(q_valid),
    .q_tag  (q_tag),
    .q_set  (q_set),
    .q_row  (q_row),
    .q_lane (q_lane),
    .q_wl   (q_wl)
  );

  // back: tag ram, hit and victim choice, recency update, response register
  sacl_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .q_valid(q_valid),
    .q_tag  (q_tag),
    .q_set  (q_set),
    .q_row  (q_row),
    .q_lane (q_lane),
    .q_wl   (q_wl),
    .stat   (stat),
    .rsp    (rsp)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the set-associative cache tag lookup
// Feeds address streams under a series of cache geometries, keeps its own
// copy of tags, valid bits, recency ranks and the victim lfsr, and compares
// every response transfer with the predicted hit, set and way.
// ----------------------------------------------------------------------------
module tb;

  localparam int ENTRIES    = 32;
  localparam int ENTRY_LOG  = 5;        // log2 of ENTRIES, caps sets * ways
  localparam int RAND_ITEMS = 100;      // random lookups per geometry
  localparam int GEO_PHASES = 8;
  localparam int LIMIT      = 200000;   // cycles before the run is abandoned

  // --------------------------------------------------------------------------
  // tag store mirror and queue of predicted lookup results
  // --------------------------------------------------------------------------
  class tag_lookup_scoreboard;
    typedef struct {
      logic                       hit;
      logic [sacl_pkg::SET_W-1:0] set_no;
      logic [sacl_pkg::WAY_W-1:0] way;
    } lookup_t;

    lookup_t                      predicted_lookups[$];
    logic [31:0]                  line_tag[ENTRIES];
    bit                           line_valid[ENTRIES];
    logic [sacl_pkg::RANK_W-1:0]  line_rank[ENTRIES];
    logic [sacl_pkg::LFSR_W-1:0]  victim_lfsr;
    sacl_pkg::cfg_t               cfg;
    int                           errors, checked, hits, misses;

    function new();
      foreach (line_tag[i]) begin
        line_tag[i]   = '0;
        line_valid[i] = 1'b0;
        line_rank[i]  = '0;
      end
      victim_lfsr     = sacl_pkg::LFSR_SEED;
      cfg.offset_bits = sacl_pkg::RST_OFFSET_BITS;
      cfg.index_bits  = sacl_pkg::RST_INDEX_BITS;
      cfg.ways_log    = sacl_pkg::RST_WAYS_LOG;
      cfg.use_lru     = sacl_pkg::RST_USE_LRU;
    endfunction

    // clamp index bits first, then ways to whatever the store has left
    function void effective_geometry(output int ib, output int wl);
      ib = (cfg.index_bits > sacl_pkg::GEO_MAX) ? sacl_pkg::GEO_MAX : int'(cfg.index_bits);
      wl = (cfg.ways_log > sacl_pkg::GEO_MAX) ? sacl_pkg::GEO_MAX : int'(cfg.ways_log);
      if (ib > ENTRY_LOG) ib = ENTRY_LOG;
      if (wl > ENTRY_LOG - ib) wl = ENTRY_LOG - ib;
    endfunction

    function int pending();
      return predicted_lookups.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("tb: mismatch: %s", msg);
    endfunction

    function void note_access(logic [31:0] addr);
      int                          ib, wl, nways, set_no, base, w;
      logic [31:0]                 tag;
      logic [sacl_pkg::RANK_W-1:0] old_rank;
      bit                          hit, found, was_valid;
      lookup_t                     res;
      effective_geometry(ib, wl);
      nways  = 1 << wl;
      set_no = int'((addr >> cfg.offset_bits) & ((32'd1 << ib) - 32'd1));
      tag    = (addr >> cfg.offset_bits) >> ib;
      base   = set_no << wl;
      hit    = 1'b0;
      found  = 1'b0;
      w      = 0;
      // lowest matching valid way wins
      for (int i = 0; i < nways && !found; i++)
        if (line_valid[base+i] && line_tag[base+i] == tag) begin
          w     = i;
          found = 1'b1;
          hit   = 1'b1;
        end
      // else lowest empty way
      for (int i = 0; i < nways && !found; i++)
        if (!line_valid[base+i]) begin
          w     = i;
          found = 1'b1;
        end
      if (!found) begin
        if (cfg.use_lru) begin
          w = 0;
          for (int i = 1; i < nways; i++)
            if (line_rank[base+i] > line_rank[base+w]) w = i;
        end else begin
          victim_lfsr = {victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5],
                         victim_lfsr[sacl_pkg::LFSR_W-1:1]};
          w = int'(victim_lfsr) & (nways - 1);
        end
      end
      // age valid ways newer than the used way (all, if it was empty), make it newest
      was_valid = line_valid[base+w];
      old_rank  = line_rank[base+w];
      for (int i = 0; i < nways; i++)
        if (i != w && line_valid[base+i] && (!was_valid || line_rank[base+i] < old_rank))
          if (line_rank[base+i] != sacl_pkg::RANK_MAX) line_rank[base+i]++;
      line_rank[base+w]  = '0;
      line_tag[base+w]   = tag;
      line_valid[base+w] = 1'b1;
      res.hit    = hit;
      res.set_no = set_no[sacl_pkg::SET_W-1:0];
      res.way    = w[sacl_pkg::WAY_W-1:0];
      if (hit) hits++;
      else misses++;
      predicted_lookups.insert(predicted_lookups.size(), res);
    endfunction

    function void check_result(logic hit, logic [sacl_pkg::SET_W-1:0] set_no,
                               logic [sacl_pkg::WAY_W-1:0] way);
      lookup_t res;
      if (predicted_lookups.size() == 0) begin
        flag($sformatf("response with nothing outstanding (hit %b set %0d way %0d)",
                       hit, set_no, way));
        return;
      end
      res = predicted_lookups.pop_front();
      checked++;
      if (hit !== res.hit)
        flag($sformatf("lookup %0d hit: expected %b, got %b", checked, res.hit, hit));
      if (set_no !== res.set_no)
        flag($sformatf("lookup %0d set_number: expected %0d, got %0d",
                       checked, res.set_no, set_no));
      if (way !== res.way)
        flag($sformatf("lookup %0d way_used: expected %0d, got %0d", checked, res.way, way));
    endfunction

    function void flag_leftovers();
      while (predicted_lookups.size() != 0) begin
        void'(predicted_lookups.pop_front());
        flag("predicted lookup never answered");
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_wdata;
  bit                              no_idle;      // long stretch where neither side pauses
  int                              cycles;
  int                              geometries;

  tag_lookup_scoreboard sb = new();

  sacl_in_if #(.ADDRESS_BITS(32)) req_if ();
  sacl_out_if                     rsp_if ();

  set_assoc_cache_tag_lookup #(
    .MAX_ENTRIES  (ENTRIES),
    .ADDRESS_BITS (32)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: a stuck handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: watchdog expired after %0d cycles", cycles);
      $display("tb: done, errors");
      $finish;
    end
  end

  // response side stalls at random, about one time in ten, except while no_idle is set
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= no_idle || ($urandom_range(0, 99) >= 10);
    end
  end

  // sample at the edge, before this edge's updates land
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready)
      sb.check_result(rsp_if.hit, rsp_if.set_number, rsp_if.way_used);
  end

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  // one address transfer; valid stays high for a back-to-back follower
  task automatic send_addr(input logic [31:0] addr);
    req_if.valid   <= 1'b1;
    req_if.address <= addr;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_access(addr);
  endtask

  // occasional random gap between requests
  task automatic maybe_gap();
    if (!no_idle && $urandom_range(0, 99) < 10) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding lookup to come back
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // program all four registers back to back; only called when drained
  task automatic set_geometry(input logic [2:0] off, input logic [2:0] ib,
                              input logic [2:0] wl, input logic lru);
    cfg_we    <= 1'b1;
    cfg_index <= sacl_pkg::CFG_OFFSET_BITS;
    cfg_wdata <= off;
    @(posedge clk);
    cfg_index <= sacl_pkg::CFG_INDEX_BITS;
    cfg_wdata <= ib;
    @(posedge clk);
    cfg_index <= sacl_pkg::CFG_WAYS_LOG;
    cfg_wdata <= wl;
    @(posedge clk);
    cfg_index <= sacl_pkg::CFG_USE_LRU;
    cfg_wdata <= {2'b00, lru};
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.cfg.offset_bits = off;
    sb.cfg.index_bits  = ib;
    sb.cfg.ways_log    = wl;
    sb.cfg.use_lru     = lru;
    geometries++;
  endtask

  // mostly addresses from a small tag pool so sets fill, hit and evict;
  // the rest fully random to toggle every address bit
  function automatic logic [31:0] pick_address(input logic [31:0] pool_base);
    int          ib, wl, off;
    logic [63:0] a;
    logic [31:0] tag;
    sb.effective_geometry(ib, wl);
    off = int'(sb.cfg.offset_bits);
    if ($urandom_range(0, 99) >= 75) return $urandom;
    tag = pool_base + $urandom_range(0, (1 << wl) + 3);
    a   = ({32'b0, tag} << (off + ib))
        | (64'($urandom_range(0, (1 << ib) - 1)) << off)
        | (64'($urandom) & ((64'd1 << off) - 64'd1));
    return a[31:0];
  endfunction

  initial begin : stimulus
    logic [31:0] pool_base;
    int          n;
    // all inputs known from time zero
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = sacl_pkg::CFG_OFFSET_BITS;
    cfg_wdata      = '0;
    req_if.valid   = 1'b0;
    req_if.address = '0;
    no_idle        = 1'b0;
    geometries     = 1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed: reset geometry, 8 sets direct mapped, 2-byte blocks
    send_addr(32'h0000_0000);             // cold miss set 0
    send_addr(32'h0000_0001);             // hit via offset bit
    send_addr(32'hFFFF_FFFF);             // all ones, set 7
    send_addr(32'hFFFF_FFFE);             // hit
    send_addr(32'h0000_0002);             // set 1, tag zero
    send_addr(32'h0000_0010);             // conflict in set 0, replace
    send_addr(32'h0000_0000);             // replaces back
    send_addr(32'h0000_0004);             // set 2, tag zero
    send_addr(32'h0000_0006);             // set 3, tag zero
    send_addr(32'h8000_0000);             // top bit only, set 0

    // regroup the same lines as one 8-way set: entries survive, several ways
    // now carry tag zero, ranks all tie at zero
    drain();
    set_geometry(3'd1, 3'd0, 3'd3, 1'b1);
    send_addr(32'h0000_0000);             // lowest of several matching ways
    send_addr(32'h1FFF_FFFE);             // old set 7 line hits in way 7
    send_addr(32'h0000_0100);             // fill empty ways
    send_addr(32'h0000_0200);
    send_addr(32'h0000_0300);
    send_addr(32'h0000_0400);             // set full, lru victim

    // same set, pseudo-random victims
    drain();
    set_geometry(3'd1, 3'd0, 3'd3, 1'b0);
    send_addr(32'h0000_0500);
    send_addr(32'h0000_0600);
    send_addr(32'h0000_0700);

    // oversized geometry: index bits and ways clip to 32 sets of one way
    drain();
    set_geometry(3'd7, 3'd7, 3'd7, 1'b1);
    send_addr(32'hFFFF_FFFF);
    send_addr(32'h0000_0000);
    send_addr(32'h8000_0080);

    // fully associative with all 32 ways, no block offset
    drain();
    set_geometry(3'd0, 3'd0, 3'd7, 1'b1);
    send_addr(32'h0000_0000);
    send_addr(32'hFFFF_FFFF);

    // ---- random phases, one geometry each, extremes first
    for (int ph = 0; ph < GEO_PHASES; ph++) begin
      drain();
      case (ph)
        0:       set_geometry(3'd0, 3'd0, 3'd5, 1'b1);   // 32-way fully associative
        1:       set_geometry(3'd4, 3'd5, 3'd0, 1'b1);   // 32 sets direct mapped
        2:       set_geometry(3'd2, 3'd2, 3'd3, 1'b0);   // 4 sets x 8 ways, random
        3:       set_geometry(3'd3, 3'd1, 3'd7, 1'b1);   // ways clipped to 16
        4:       set_geometry(3'd5, 3'd6, 3'd2, 1'b0);   // sets saturate, ways cut
        5:       set_geometry(3'd1, 3'd3, 3'd2, 1'b1);   // 8 sets x 4 ways
        default: set_geometry(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                              3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      endcase
      no_idle   = (ph == 2);
      pool_base = $urandom;
      for (n = 0; n < RAND_ITEMS; n++) begin
        maybe_gap();
        // mid-phase hold-off until every lookup has answered
        if (ph == 3 && n == RAND_ITEMS / 2) drain();
        send_addr(pick_address(pool_base));
      end
    end

    // ---- wind down: drain, let the pipeline settle, then judge
    drain();
    no_idle = 1'b0;
    repeat (20) @(posedge clk);
    sb.flag_leftovers();
    $display("tb: %0d lookups checked, %0d hits and %0d misses, across %0d geometries",
             sb.checked, sb.hits, sb.misses, geometries);
    $display("tb: %0d mismatches", sb.errors);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
